// File: sv/m4inv_pkg.sv
// Shared types, constants and product sequencing for the 4x4 matrix inverse core.
`default_nettype none

package m4inv_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int IO_WIDTH       = 32;
    localparam int CHUNK          = 16;

    typedef enum logic [1:0] {
        BSRC_ELEM,
        BSRC_MINOR,
        BSRC_COF
    } bsrc_t;

    typedef enum logic [1:0] {
        DST_MINOR,
        DST_COF,
        DST_DET
    } dst_t;

    typedef enum logic [1:0] {
        PH_MINOR,
        PH_COF,
        PH_DET
    } phase_t;

    // One product term: a = element, b = element / 2x2 minor / cofactor
    typedef struct packed {
        logic [3:0] a_idx;
        logic [3:0] b_idx;
        bsrc_t      b_src;
        logic       sub;
        logic       first;
        logic       last;
        dst_t       dst;
        logic [3:0] dst_idx;
    } prod_op_t;

    typedef struct packed {
        logic       load;
        logic [3:0] wr_idx;
        logic       fetch;
        logic       loadb;
        logic       mul;
        logic       mul_first;
        logic       acc;
        logic       div_init;
        logic       div_step;
        logic       div_done;
        prod_op_t   op;
    } dp_cmd_t;

    // column pair (x < y) to minor slot
    function automatic logic [2:0] pair_idx(input logic [1:0] x, input logic [1:0] y);
        logic [2:0] p;
        begin
            unique case (x)
                2'd0:    p = {1'b0, y} - 3'd1;
                2'd1:    p = {1'b0, y} + 3'd1;
                default: p = 3'd5;
            endcase
            return p;
        end
    endfunction

    // k-th column of the three that remain when column c is dropped
    function automatic logic [1:0] col_skip(input logic [1:0] c, input logic [1:0] k);
        begin
            return (k < c) ? k : k + 2'd1;
        end
    endfunction

    function automatic prod_op_t op_decode(input phase_t ph, input logic [3:0] cnt,
                                           input logic [1:0] sub);
        prod_op_t   o;
        logic       bottom;
        logic [2:0] pi;
        logic [1:0] x, y, ra, rb, r, c, er, p, q;
        logic [3:0] base;
        begin
            o      = '0;
            bottom = 1'b0;
            pi     = 3'd0;
            x      = 2'd0;
            y      = 2'd1;
            ra     = 2'd0;
            rb     = 2'd0;
            r      = cnt[3:2];
            c      = cnt[1:0];
            er     = 2'd0;
            p      = 2'd0;
            q      = 2'd0;
            base   = 4'd0;
            unique case (ph)
                PH_MINOR:
                begin
                    // slots 0..5 use rows 2,3; slots 6..11 use rows 0,1
                    bottom = (cnt < 4'd6);
                    pi     = bottom ? cnt[2:0] : 3'(cnt - 4'd6);
                    unique case (pi)
                        3'd0:    begin x = 2'd0; y = 2'd1; end
                        3'd1:    begin x = 2'd0; y = 2'd2; end
                        3'd2:    begin x = 2'd0; y = 2'd3; end
                        3'd3:    begin x = 2'd1; y = 2'd2; end
                        3'd4:    begin x = 2'd1; y = 2'd3; end
                        default: begin x = 2'd2; y = 2'd3; end
                    endcase
                    ra        = bottom ? 2'd2 : 2'd0;
                    rb        = ra + 2'd1;
                    o.b_src   = BSRC_ELEM;
                    o.dst     = DST_MINOR;
                    o.dst_idx = cnt;
                    if (sub[0] == 1'b0)
                    begin
                        o.a_idx = {ra, x};
                        o.b_idx = {rb, y};
                        o.first = 1'b1;
                    end
                    else
                    begin
                        o.a_idx = {ra, y};
                        o.b_idx = {rb, x};
                        o.sub   = 1'b1;
                        o.last  = 1'b1;
                    end
                end
                PH_COF:
                begin
                    // rows 0,1 expand along the other top row with bottom minors;
                    // rows 2,3 along the other bottom row with top minors
                    er = r ^ 2'd1;
                    base = r[1] ? 4'd6 : 4'd0;
                    unique case (sub)
                        2'd0:    begin p = col_skip(c, 2'd1); q = col_skip(c, 2'd2); end
                        2'd1:    begin p = col_skip(c, 2'd0); q = col_skip(c, 2'd2); end
                        default: begin p = col_skip(c, 2'd0); q = col_skip(c, 2'd1); end
                    endcase
                    o.a_idx   = {er, col_skip(c, sub)};
                    o.b_idx   = base + {1'b0, pair_idx(p, q)};
                    o.b_src   = BSRC_MINOR;
                    o.sub     = sub[0] ^ r[0] ^ c[0];
                    o.first   = (sub == 2'd0);
                    o.last    = (sub == 2'd2);
                    o.dst     = DST_COF;
                    o.dst_idx = cnt;
                end
                default:
                begin
                    o.a_idx   = {2'd0, cnt[1:0]};
                    o.b_idx   = {2'd0, cnt[1:0]};
                    o.b_src   = BSRC_COF;
                    o.first   = (cnt[1:0] == 2'd0);
                    o.last    = (cnt[1:0] == 2'd3);
                    o.dst     = DST_DET;
                    o.dst_idx = cnt;
                end
            endcase
            return o;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/m4inv_datapath.sv
// Datapath: element store, chunked multiply-accumulate, minor/cofactor registers, divider.
`default_nettype none

module m4inv_datapath
    import m4inv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dp_cmd_t                    cmd,
    input  wire logic signed [IO_WIDTH-1:0] element_value,
    output logic                            det_zero,
    output logic signed [IO_WIDTH-1:0]      inverse_value,
    output logic                            singular
);

    localparam int W   = DATA_WIDTH;
    localparam int MW  = 2 * W + 2;
    localparam int CW  = 3 * W + 3;
    localparam int NCH = (CW + CHUNK - 1) / CHUNK;
    localparam int BW  = NCH * CHUNK;
    localparam int PW  = W + BW;
    localparam int DW  = 4 * W + 4;
    localparam int NW  = CW + 2 * FRAC_BITS;
    localparam int QW  = W + 2;

    logic        [W-1:0]  mat_mem [16];
    logic signed [W-1:0]  rd_a_reg;
    logic signed [W-1:0]  rd_b_reg;
    logic signed [MW-1:0] minor_reg [12];
    logic signed [CW-1:0] cof_reg [16];
    logic signed [BW-1:0] opb_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] acc_reg;
    logic        [DW-1:0] det_mag_reg;
    logic                 det_neg_reg;
    logic                 det_zero_reg;
    logic        [NW-1:0] num_reg;
    logic        [DW-1:0] rem_reg;
    logic        [W:0]    q_reg;
    logic                 ovf_reg;
    logic                 neg_reg;
    logic signed [IO_WIDTH-1:0] inverse_value_reg;
    logic                 singular_reg;

    logic        [CHUNK-1:0]   chunk;
    logic signed [CHUNK:0]     chunk_ext;
    logic signed [W+CHUNK:0]   pp;
    logic signed [PW-1:0]      prod_next;
    logic signed [PW-1:0]      acc_base;
    logic signed [PW-1:0]      acc_next;
    logic signed [PW-1:0]      acc_mag;
    logic signed [BW-1:0]      opb_next;
    logic signed [CW-1:0]      cof_sel;
    logic        [CW-1:0]      cof_mag;
    logic        [DW:0]        r_sh;
    logic                      r_ge;
    logic        [DW:0]        r_sub;
    logic                      rnd;
    logic        [QW-1:0]      mag;
    logic        [QW-1:0]      lim;
    logic        [QW-1:0]      fmag;
    logic signed [W-1:0]       res;

    // element store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mat_mem[cmd.wr_idx] <= W'(element_value);
        end
        if (cmd.fetch)
        begin
            rd_a_reg <= mat_mem[cmd.op.a_idx];
            rd_b_reg <= mat_mem[cmd.op.b_idx];
        end
    end

    always_comb
    begin
        unique case (cmd.op.b_src)
            BSRC_ELEM:  opb_next = BW'(rd_b_reg);
            BSRC_MINOR: opb_next = BW'(minor_reg[cmd.op.b_idx]);
            default:    opb_next = BW'(cof_reg[cmd.op.b_idx]);
        endcase
    end

    // Horner over 16-bit chunks of b, top chunk signed
    assign chunk     = opb_reg[BW-1 -: CHUNK];
    assign chunk_ext = cmd.mul_first ? {chunk[CHUNK-1], chunk} : {1'b0, chunk};
    assign pp        = rd_a_reg * chunk_ext;
    assign prod_next = (cmd.mul_first ? PW'(0) : (prod_reg <<< CHUNK)) + PW'(pp);

    assign acc_base = cmd.op.first ? PW'(0) : acc_reg;
    assign acc_next = cmd.op.sub ? (acc_base - prod_reg) : (acc_base + prod_reg);
    assign acc_mag  = acc_next[PW-1] ? -acc_next : acc_next;

    assign cof_sel = cof_reg[cmd.op.b_idx];
    assign cof_mag = cof_sel[CW-1] ? CW'(-cof_sel) : CW'(cof_sel);

    assign r_sh  = {rem_reg, num_reg[NW-1]};
    assign r_ge  = (r_sh >= {1'b0, det_mag_reg});
    assign r_sub = r_sh - {1'b0, det_mag_reg};

    // round half away from zero on magnitudes, then clamp
    assign rnd  = ({rem_reg, 1'b0} >= {1'b0, det_mag_reg});
    assign mag  = {1'b0, q_reg} + QW'(rnd);
    assign lim  = neg_reg ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
    assign fmag = (ovf_reg || (mag > lim)) ? lim : mag;
    assign res  = neg_reg ? W'(-fmag) : W'(fmag);

    always_ff @(posedge clk)
    begin
        if (cmd.loadb)
        begin
            opb_reg <= opb_next;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
            opb_reg  <= opb_reg <<< CHUNK;
        end
        if (cmd.acc)
        begin
            acc_reg <= acc_next;
            if (cmd.op.last)
            begin
                unique case (cmd.op.dst)
                    DST_MINOR: minor_reg[cmd.op.dst_idx] <= acc_next[MW-1:0];
                    DST_COF:   cof_reg[cmd.op.dst_idx]   <= acc_next[CW-1:0];
                    default:
                    begin
                        det_mag_reg <= acc_mag[DW-1:0];
                        det_neg_reg <= acc_next[PW-1];
                    end
                endcase
            end
        end
        if (cmd.div_init)
        begin
            num_reg <= NW'(cof_mag) << (2 * FRAC_BITS);
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
            neg_reg <= cof_sel[CW-1] ^ det_neg_reg;
        end
        if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= r_ge ? r_sub[DW-1:0] : r_sh[DW-1:0];
            q_reg   <= {q_reg[W-1:0], r_ge};
            ovf_reg <= ovf_reg | q_reg[W];
        end
        if (cmd.div_done)
        begin
            inverse_value_reg <= det_zero_reg ? IO_WIDTH'(0) : IO_WIDTH'(res);
            singular_reg      <= det_zero_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_zero_reg <= 1'b0;
        end
        else if (cmd.acc && cmd.op.last && (cmd.op.dst == DST_DET))
        begin
            det_zero_reg <= (acc_next == PW'(0));
        end
    end

    assign det_zero      = det_zero_reg;
    assign inverse_value = inverse_value_reg;
    assign singular      = singular_reg;

endmodule

`default_nettype wire

// File: sv/m4inv_ctrl.sv
// Controller: load counting, product sequencing, divide and output handshake.
`default_nettype none

module m4inv_ctrl
    import m4inv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    element_valid,
    output logic         element_ready,
    input  wire logic    det_zero,
    output dp_cmd_t      cmd,
    output logic         inverse_valid,
    input  wire logic    inverse_ready,
    output logic         last_flag
);

    localparam int W   = DATA_WIDTH;
    localparam int CW  = 3 * W + 3;
    localparam int NCH = (CW + CHUNK - 1) / CHUNK;
    localparam int NW  = CW + 2 * FRAC_BITS;
    localparam int CCW = $clog2(NCH);
    localparam int DCW = $clog2(NW);

    typedef enum logic [3:0] {
        S_LOAD,
        S_FETCH,
        S_LOADB,
        S_MUL,
        S_ACC,
        S_DINIT,
        S_DIV,
        S_ROUND,
        S_EMIT
    } state_t;

    state_t         state_reg, state_next;
    logic [3:0]     load_cnt_reg, load_cnt_next;
    phase_t         phase_reg, phase_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic [1:0]     sub_reg, sub_next;
    logic [CCW-1:0] chunk_cnt_reg, chunk_cnt_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic [3:0]     out_idx_reg, out_idx_next;
    logic           valid_reg, valid_next;
    logic           last_reg, last_next;
    prod_op_t       op;

    always_comb
    begin
        op = op_decode(phase_reg, cnt_reg, sub_reg);
        // during divide setup the b index selects cofactor (col, row) for a transpose
        if (state_reg == S_DINIT)
        begin
            op.b_idx = {out_idx_reg[1:0], out_idx_reg[3:2]};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        sub_next       = sub_reg;
        chunk_cnt_next = chunk_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        out_idx_next   = out_idx_reg;
        valid_next     = valid_reg;
        last_next      = last_reg;

        cmd           = '0;
        cmd.op        = op;
        cmd.wr_idx    = load_cnt_reg;
        cmd.mul_first = (chunk_cnt_reg == CCW'(0));

        unique case (state_reg)
            S_LOAD:
            begin
                if (element_valid)
                begin
                    cmd.load      = 1'b1;
                    load_cnt_next = load_cnt_reg + 4'd1;
                    if (load_cnt_reg == 4'd15)
                    begin
                        phase_next = PH_MINOR;
                        cnt_next   = 4'd0;
                        sub_next   = 2'd0;
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_LOADB;
            end
            S_LOADB:
            begin
                cmd.loadb      = 1'b1;
                chunk_cnt_next = '0;
                state_next     = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                if (chunk_cnt_reg == CCW'(NCH - 1))
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    chunk_cnt_next = chunk_cnt_reg + CCW'(1);
                end
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_FETCH;
                unique case (phase_reg)
                    PH_MINOR:
                    begin
                        if (sub_reg == 2'd1)
                        begin
                            sub_next = 2'd0;
                            if (cnt_reg == 4'd11)
                            begin
                                phase_next = PH_COF;
                                cnt_next   = 4'd0;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 4'd1;
                            end
                        end
                        else
                        begin
                            sub_next = 2'd1;
                        end
                    end
                    PH_COF:
                    begin
                        if (sub_reg == 2'd2)
                        begin
                            sub_next = 2'd0;
                            if (cnt_reg == 4'd15)
                            begin
                                phase_next = PH_DET;
                                cnt_next   = 4'd0;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 4'd1;
                            end
                        end
                        else
                        begin
                            sub_next = sub_reg + 2'd1;
                        end
                    end
                    default:
                    begin
                        if (cnt_reg == 4'd3)
                        begin
                            out_idx_next = 4'd0;
                            state_next   = S_DINIT;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 4'd1;
                        end
                    end
                endcase
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = det_zero ? S_ROUND : S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DCW'(NW - 1))
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + DCW'(1);
                end
            end
            S_ROUND:
            begin
                cmd.div_done = 1'b1;
                valid_next   = 1'b1;
                last_next    = (out_idx_reg == 4'd15);
                state_next   = S_EMIT;
            end
            default:
            begin
                if (inverse_ready)
                begin
                    valid_next = 1'b0;
                    if (out_idx_reg == 4'd15)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 4'd1;
                        state_next   = S_DINIT;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            load_cnt_reg  <= '0;
            phase_reg     <= PH_MINOR;
            cnt_reg       <= '0;
            sub_reg       <= '0;
            chunk_cnt_reg <= '0;
            div_cnt_reg   <= '0;
            out_idx_reg   <= '0;
            valid_reg     <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            sub_reg       <= sub_next;
            chunk_cnt_reg <= chunk_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            out_idx_reg   <= out_idx_next;
            valid_reg     <= valid_next;
            last_reg      <= last_next;
        end
    end

    assign element_ready = (state_reg == S_LOAD);
    assign inverse_valid = valid_reg;
    assign last_flag     = last_reg;

endmodule

`default_nettype wire

// File: sv/matrix4_inverse_core.sv
// 4x4 fixed-point matrix inverse: element in, inverse elements out.
//
// Input channel (element_valid/element_ready): sixteen words, row-major, signed
// Q16.16 at default widths. Each is taken as soon as it is offered while the
// core is loading. After the sixteenth word the core computes twelve 2x2
// minors, sixteen cofactors and the determinant (76 products) with one shared
// multiplier that takes b in 16-bit chunks, NCH = ceil((3*DATA_WIDTH+3)/16)
// of them. Each output word then runs a restoring divider for
// 3*DATA_WIDTH+3+2*FRAC_BITS steps (131 at defaults), with setup before and
// rounding and the handoff after; a singular matrix skips the divider steps.
// Output channel (inverse_valid/inverse_ready): sixteen words, row-major,
// rounded to nearest and saturated; last_flag marks the sixteenth. A zero
// determinant gives zeros with singular set. While the receiver stalls the word
// holds and the core waits; no new element is taken until all sixteen leave.
// Reset returns the core to loading at element zero with no output pending.
`default_nettype none

module matrix4_inverse_core
    import m4inv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       element_valid,
    output logic                            element_ready,
    input  wire logic signed [IO_WIDTH-1:0] element_value,
    output logic                            inverse_valid,
    input  wire logic                       inverse_ready,
    output logic signed [IO_WIDTH-1:0]      inverse_value,
    output logic                            singular,
    output logic                            last_flag
);

    dp_cmd_t cmd;
    logic    det_zero;

    m4inv_ctrl #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_valid (element_valid),
        .element_ready (element_ready),
        .det_zero      (det_zero),
        .cmd           (cmd),
        .inverse_valid (inverse_valid),
        .inverse_ready (inverse_ready),
        .last_flag     (last_flag)
    );

    m4inv_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .element_value (element_value),
        .det_zero      (det_zero),
        .inverse_value (inverse_value),
        .singular      (singular)
    );

endmodule

`default_nettype wire

// File: dv/matrix4_inverse_checker.sv
// Checker for the 4x4 matrix inverse core: collects loaded elements, predicts inverse words and compares.
module matrix4_inverse_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               element_valid,
    input  logic               element_ready,
    input  logic signed [31:0] element_value,
    input  logic               inverse_valid,
    input  logic               inverse_ready,
    input  logic signed [31:0] inverse_value,
    input  logic               singular,
    input  logic               last_flag,
    output int                 error_count,
    output int                 pending_count,
    output int                 words_seen,
    output int                 singular_seen,
    output int                 saturated_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic [31:0] value;
        logic        sing;
        logic        last;
    } inverse_word_t;

    inverse_word_t expected_words[$];
    logic signed [31:0] loaded[16];
    int load_pos;

    function automatic wide_t elem(int r, int c);
        return wide_t'(loaded[r * 4 + c]);
    endfunction

    // 3x3 determinant with row sr and column sc dropped
    function automatic wide_t minor3(int sr, int sc);
        int    rs[3];
        int    cs[3];
        int    k;
        wide_t t1, t2, t3;
        k = 0;
        for (int i = 0; i < 4; i++)
            if (i != sr)
            begin
                rs[k] = i;
                k++;
            end
        k = 0;
        for (int i = 0; i < 4; i++)
            if (i != sc)
            begin
                cs[k] = i;
                k++;
            end
        t1 = elem(rs[1], cs[1]) * elem(rs[2], cs[2]) - elem(rs[1], cs[2]) * elem(rs[2], cs[1]);
        t2 = elem(rs[1], cs[0]) * elem(rs[2], cs[2]) - elem(rs[1], cs[2]) * elem(rs[2], cs[0]);
        t3 = elem(rs[1], cs[0]) * elem(rs[2], cs[1]) - elem(rs[1], cs[1]) * elem(rs[2], cs[0]);
        return elem(rs[0], cs[0]) * t1 - elem(rs[0], cs[1]) * t2 + elem(rs[0], cs[2]) * t3;
    endfunction

    // round-to-nearest (ties away) of num/den, saturated to 32-bit signed
    function automatic logic [31:0] scaled_quotient(wide_t num, wide_t den);
        logic        neg;
        logic [191:0] na, da, q, r;
        neg = (num < 0) != (den < 0);
        na = (num < 0) ? -num : num;
        da = (den < 0) ? -den : den;
        q = na / da;
        r = na % da;
        if ((r << 1) >= da)
            q = q + 1;
        if (neg)
            return (q > 192'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        return (q > 192'h7fff_ffff) ? 32'h7fff_ffff : 32'(q);
    endfunction

    task automatic predict_inverse();
        wide_t         cof[16];
        wide_t         det;
        inverse_word_t w;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                cof[i * 4 + j] = ((i + j) % 2) ? -minor3(i, j) : minor3(i, j);
        det = 0;
        for (int j = 0; j < 4; j++)
            det = det + elem(0, j) * cof[j];
        for (int k = 0; k < 16; k++)
        begin
            w.sing  = (det == 0);
            w.last  = (k == 15);
            w.value = w.sing ? 32'd0 : scaled_quotient(cof[(k % 4) * 4 + k / 4] <<< 32, det);
            expected_words.push_back(w);
        end
    endtask

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        $display("MISMATCH word %0d %s: expected %h got %h", words_seen, field, want, got);
        error_count++;
    endtask

    initial
    begin
        error_count = 0;
        pending_count = 0;
        words_seen = 0;
        singular_seen = 0;
        saturated_seen = 0;
        load_pos = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && element_valid && element_ready)
        begin
            loaded[load_pos] = element_value;
            load_pos++;
            if (load_pos == 16)
            begin
                load_pos = 0;
                predict_inverse();
            end
        end
        if (rst_n && inverse_valid && inverse_ready)
        begin
            inverse_word_t w;
            if (expected_words.size() == 0)
            begin
                report("unexpected word", 32'd0, inverse_value);
            end
            else
            begin
                w = expected_words.pop_front();
                if (w.value != inverse_value)
                    report("inverse_value", w.value, inverse_value);
                if (w.sing != singular)
                    report("singular", 32'(w.sing), 32'(singular));
                if (w.last != last_flag)
                    report("last_flag", 32'(w.last), 32'(last_flag));
                if (w.sing)
                    singular_seen++;
                if (w.value == 32'h7fff_ffff || w.value == 32'h8000_0000)
                    saturated_seen++;
            end
            words_seen++;
        end
        pending_count = expected_words.size();
    end
endmodule

// File: dv/matrix4_inverse_core_test.sv
// Top of the 4x4 matrix inverse testbench: clock, reset, element stimulus and verdict.
module matrix4_inverse_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               element_valid;
    logic               element_ready;
    logic signed [31:0] element_value;
    logic               inverse_valid;
    logic               inverse_ready;
    logic signed [31:0] inverse_value;
    logic               singular;
    logic               last_flag;
    int                 error_count;
    int                 pending_count;
    int                 words_seen;
    int                 singular_seen;
    int                 saturated_seen;
    logic               sender_burst;
    logic               receiver_burst;
    int                 matrices_sent;

    matrix4_inverse_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_valid (element_valid),
        .element_ready (element_ready),
        .element_value (element_value),
        .inverse_valid (inverse_valid),
        .inverse_ready (inverse_ready),
        .inverse_value (inverse_value),
        .singular      (singular),
        .last_flag     (last_flag)
    );

    matrix4_inverse_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .element_valid  (element_valid),
        .element_ready  (element_ready),
        .element_value  (element_value),
        .inverse_valid  (inverse_valid),
        .inverse_ready  (inverse_ready),
        .inverse_value  (inverse_value),
        .singular       (singular),
        .last_flag      (last_flag),
        .error_count    (error_count),
        .pending_count  (pending_count),
        .words_seen     (words_seen),
        .singular_seen  (singular_seen),
        .saturated_seen (saturated_seen)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // called at a falling edge; returns at a falling edge after the word is taken
    task automatic send_element(logic [31:0] v);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            element_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        element_valid <= 1'b1;
        element_value <= v;
        do
            @(posedge clk);
        while (!(element_valid && element_ready));
        @(negedge clk);
    endtask

    task automatic send_matrix(logic [31:0] m[16]);
        sender_burst = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < 16; k++)
            send_element(m[k]);
        matrices_sent++;
    endtask

    function automatic logic [31:0] small_fixed();
        // within about +-8.0 in Q16.16
        return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    endfunction

    initial
    begin
        logic [31:0] m[16];
        int          kind;
        rst_n = 1'b0;
        element_valid = 1'b0;
        element_value = '0;
        matrices_sent = 0;
        sender_burst = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // tiny diagonal: inverse overflows both ways
        for (int k = 0; k < 16; k++)
            m[k] = 32'd0;
        m[0] = 32'd1;
        m[5] = 32'hffff_ffff;
        m[10] = 32'h0001_0000;
        m[15] = 32'h0000_0002;
        send_matrix(m);
        // two equal rows of extremes: singular
        for (int k = 0; k < 16; k++)
            m[k] = $urandom;
        for (int c = 0; c < 4; c++)
        begin
            m[c] = (c % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
            m[4 + c] = m[c];
        end
        send_matrix(m);

        for (int n = 0; n < 28; n++)
        begin
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 16; k++)
                m[k] = (kind < 3) ? $urandom : small_fixed();
            if (kind == 9)
                for (int c = 0; c < 4; c++)
                    m[12 + c] = m[4 + c];
            else if (kind == 8)
                for (int r = 0; r < 4; r++)
                    m[r * 4 + 2] = 32'd0;
            send_matrix(m);
        end
        element_valid <= 1'b0;

        fork
            wait (pending_count == 0);
            begin
                repeat (200000) @(posedge clk);
                $display("Timeout waiting for inverse words");
            end
        join_any
        disable fork;
        // idle a while so any stray extra word gets caught
        repeat (3000) @(posedge clk);
        $display("Sent %0d matrices, checked %0d inverse words", matrices_sent, words_seen);
        $display("%0d words singular, %0d words saturated", singular_seen, saturated_seen);
        if (error_count == 0 && pending_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int gap;
        int taken;
        bit held;
        inverse_ready = 1'b0;
        receiver_burst = 1'b0;
        taken = 0;
        held = 0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && taken == 40)
            begin
                // long hold-off: core fills and stops taking elements
                held = 1;
                inverse_ready <= 1'b0;
                repeat (4000) @(negedge clk);
            end
            if (taken % 16 == 0)
                receiver_burst = ($urandom_range(0, 3) == 0);
            gap = receiver_burst ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                inverse_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            inverse_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(inverse_valid && inverse_ready));
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
